### rtl/core/twg_pkg.sv
// Shared types and constants for the tone waveform generator.
// Used by twg_ctrl, twg_datapath and tone_waveform_generator; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package twg_pkg;

  // Widths of the configuration registers
  localparam int PHASE_W   = 32;
  localparam int TONE_W    = 20;
  localparam int WAVE_W    = 2;
  localparam int VOL_W     = 7;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 32;

  // Reset values of the configuration registers
  localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'd42852281;
  localparam logic [TONE_W-1:0]  TONE_RST       = 20'd22050;
  localparam logic [WAVE_W-1:0]  WAVE_RST       = 2'd0;
  localparam logic [VOL_W-1:0]   VOL_RST        = 7'd70;

  localparam logic [VOL_W-1:0] VOL_MAX = 7'd100;

  // Datapath widths
  localparam int SAMPLE_W = 16;
  localparam int SINE_W   = 15;   // quarter-wave table entries, 0..32767
  localparam int VAL_W    = 19;   // signed waveform value, -262144..262143
  localparam int MAG_W    = 17;   // |waveform value| <= 32768
  localparam int ENV_W    = 16;   // envelope numerator and denominator
  localparam int PROD_A_W = MAG_W + VOL_W;      // mag * vol
  localparam int PROD_T_W = ENV_W + 15;         // env_num * 32767
  localparam int SCALE_W  = 22;
  localparam int DEN_W    = ENV_W + SCALE_W;    // env_den * 3276800
  localparam int REM_W    = 56;
  localparam int QUO_W    = 16;
  localparam int DIV_CNT_W = 4;

  // 32768 * 100: Q1.15 scale times percent
  localparam logic [SCALE_W-1:0] DIV_SCALE = 22'd3276800;

  // pi/2 in Q30, for building the quarter-wave table
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP   = 4'd0,
    REG_TONE_SAMPLES = 4'd1,
    REG_WAVEFORM     = 4'd2,
    REG_VOLUME       = 4'd3
  } cfg_reg_e;

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAW      = 2'd3
  } wave_e;

  // Controller to datapath commands, one step per cycle
  typedef struct packed {
    logic start;     // input transfer: apply restart
    logic prep1;     // length, index, fade, sine address
    logic prep2;     // envelope terms, table read
    logic wave;      // waveform value and volume clamp
    logic mul1;      // first products
    logic mul2;      // full numerator, divider load
    logic div_step;  // one quotient bit
    logic finish;    // load output register, advance or wrap phase and index
  } cmd_t;

endpackage

`default_nettype wire

### rtl/core/twg_ctrl.sv
// Sequencer for the tone generator: walks one sample through the datapath
// and owns the input/output handshakes. Depends on twg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twg_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output twg_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP1,
    S_PREP2,
    S_WAVE,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_FIN
  } state_e;

  state_e                          state_q, state_d;
  logic [twg_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic                            out_valid_q, out_valid_d;
  logic                            start;
  logic                            fin_ok;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign start       = in_valid_i && in_ready_o;
  // output register free, or emptied in this same cycle
  assign fin_ok      = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.start = 1'b1;
          state_d     = S_PREP1;
        end
      end
      S_PREP1: begin
        cmd_o.prep1 = 1'b1;
        state_d     = S_PREP2;
      end
      S_PREP2: begin
        cmd_o.prep2 = 1'b1;
        state_d     = S_WAVE;
      end
      S_WAVE: begin
        cmd_o.wave = 1'b1;
        state_d    = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        cnt_d      = twg_pkg::DIV_CNT_W'(twg_pkg::QUO_W - 1);
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_FIN: begin
        if (fin_ok) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/twg_datapath.sv
// Datapath of the tone generator: configuration registers, phase and index
// state, quarter-wave sine table, envelope, products and a restoring divider.
// Depends on twg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twg_datapath #(
  parameter int SINE_TABLE_ENTRIES = 1024,
  parameter int FADE_LIMIT         = 882,
  parameter int INDEX_BITS         = 20
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire twg_pkg::cmd_t                     cmd_i,
  input  wire logic                              restart_i,
  input  wire logic                              cfg_valid_i,
  input  wire logic [twg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [twg_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  output logic signed [twg_pkg::SAMPLE_W-1:0]    sample_o,
  output logic                                   last_o
);

  localparam int NW  = INDEX_BITS + 1;                       // holds length up to 2^INDEX_BITS
  localparam int TW  = (NW > twg_pkg::TONE_W) ? NW : twg_pkg::TONE_W;
  localparam int CW  = (NW > twg_pkg::ENV_W) ? NW : twg_pkg::ENV_W;
  localparam int XW  = CW + 1;
  localparam int EW  = $clog2(SINE_TABLE_ENTRIES + 1);       // table address
  localparam int FPW = 30 + EW;

  // Quarter-wave sine point, Taylor series in Q30, built at elaboration
  function automatic logic [twg_pkg::SINE_W-1:0] sine_point(input longint unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          q;
    x    = (k * twg_pkg::PI_HALF_Q30) / SINE_TABLE_ENTRIES;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + longint'(term);
    if (sum < 0) sum = 0;
    q = (sum + 64'sd16384) >>> 15;
    if (q > 32767) q = 32767;
    return twg_pkg::SINE_W'(q);
  endfunction

  logic [twg_pkg::SINE_W-1:0] sine_rom [SINE_TABLE_ENTRIES + 1];

  for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++) begin : g_rom
    localparam logic [twg_pkg::SINE_W-1:0] PointVal = sine_point(64'(k));
    assign sine_rom[k] = PointVal;
  end

  // Configuration and tone state
  logic [twg_pkg::PHASE_W-1:0] phase_step_q;
  logic [twg_pkg::TONE_W-1:0]  tone_q;
  logic [twg_pkg::WAVE_W-1:0]  waveform_q;
  logic [twg_pkg::VOL_W-1:0]   vol_cfg_q;
  logic [twg_pkg::PHASE_W-1:0] phase_acc_q;
  logic [INDEX_BITS-1:0]       sample_index_q;

  // Per-sample working registers
  logic [NW-1:0]                   n_q;
  logic [NW-1:0]                   i_q;
  logic [twg_pkg::ENV_W-1:0]       fade_q;
  logic                            last_q;
  logic [EW-1:0]                   rom_addr_q;
  logic [twg_pkg::SINE_W-1:0]      sine_q;
  logic [twg_pkg::ENV_W-1:0]       env_num_q;
  logic [twg_pkg::ENV_W-1:0]       env_den_q;
  logic [twg_pkg::MAG_W-1:0]       mag_q;
  logic                            neg_q;
  logic [twg_pkg::VOL_W-1:0]       vol_q;
  logic [twg_pkg::PROD_A_W-1:0]    a_q;
  logic [twg_pkg::PROD_T_W-1:0]    t_q;
  logic [twg_pkg::DEN_W-1:0]       d_q;
  logic [twg_pkg::REM_W-1:0]       rem_q;
  logic [twg_pkg::REM_W-1:0]       dsh_q;
  logic [twg_pkg::QUO_W-1:0]       quo_q;
  logic signed [twg_pkg::SAMPLE_W-1:0] sample_q;
  logic                            last_out_q;

  // Length, index and fade
  logic [TW-1:0] nz;
  logic [TW-1:0] n_lim;
  logic [NW-1:0] n_w;
  logic [NW-1:0] i_ext;
  logic [NW-1:0] q4;
  logic [CW-1:0] q4_c;
  logic [CW-1:0] fade_c;

  assign nz     = (tone_q == '0) ? TW'(1) : TW'(tone_q);
  assign n_lim  = TW'(1) << INDEX_BITS;
  assign n_w    = (nz > n_lim) ? n_lim[NW-1:0] : nz[NW-1:0];
  assign i_ext  = NW'(sample_index_q);
  assign q4     = n_w >> 2;
  assign q4_c   = CW'(q4);
  assign fade_c = (q4_c > CW'(FADE_LIMIT)) ? CW'(FADE_LIMIT) : q4_c;

  // Sine table address: quadrant fold of floor(frac * entries)
  logic [FPW-1:0] frac_prod;
  logic [EW-1:0]  tab_idx;

  assign frac_prod = FPW'(phase_acc_q[29:0]) * FPW'(SINE_TABLE_ENTRIES);
  assign tab_idx   = frac_prod[30 +: EW];

  // Envelope terms
  logic [XW-1:0] i_x;
  logic [XW-1:0] n_x;
  logic [XW-1:0] f_x;
  logic [XW-1:0] n_minus_i;

  assign i_x       = XW'(i_q);
  assign n_x       = XW'(n_q);
  assign f_x       = XW'(fade_q);
  assign n_minus_i = n_x - i_x;

  // Waveform value
  logic signed [twg_pkg::VAL_W-1:0] wave_val;
  logic signed [twg_pkg::VAL_W-1:0] tri_u;
  logic signed [twg_pkg::VAL_W-1:0] abs_val;
  logic [1:0]                       quad;

  assign quad  = phase_acc_q[31:30];
  assign tri_u = $signed({2'b00, phase_acc_q[31:15]});

  always_comb begin
    case (twg_pkg::wave_e'(waveform_q))
      twg_pkg::WAVE_SINE: begin
        wave_val = quad[1] ? -$signed(twg_pkg::VAL_W'(sine_q))
                           : $signed(twg_pkg::VAL_W'(sine_q));
      end
      twg_pkg::WAVE_SQUARE: begin
        wave_val = phase_acc_q[31] ? -19'sd32768 : 19'sd32768;
      end
      twg_pkg::WAVE_TRIANGLE: begin
        case (quad)
          2'd0:    wave_val = tri_u;
          2'd3:    wave_val = tri_u - 19'sd131072;
          default: wave_val = 19'sd65536 - tri_u;
        endcase
      end
      default: begin
        wave_val = $signed({3'b000, phase_acc_q[31:16]}) - 19'sd32768;
      end
    endcase
  end

  assign abs_val = wave_val[twg_pkg::VAL_W-1] ? -wave_val : wave_val;

  // Restoring divider step
  logic rem_ge;
  assign rem_ge = (rem_q >= dsh_q);

  // Configuration and tone state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q   <= twg_pkg::PHASE_STEP_RST;
      tone_q         <= twg_pkg::TONE_RST;
      waveform_q     <= twg_pkg::WAVE_RST;
      vol_cfg_q      <= twg_pkg::VOL_RST;
      phase_acc_q    <= '0;
      sample_index_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (twg_pkg::cfg_reg_e'(cfg_index_i))
          twg_pkg::REG_PHASE_STEP:   phase_step_q <= cfg_data_i;
          twg_pkg::REG_TONE_SAMPLES: tone_q       <= cfg_data_i[twg_pkg::TONE_W-1:0];
          twg_pkg::REG_WAVEFORM:     waveform_q   <= cfg_data_i[twg_pkg::WAVE_W-1:0];
          twg_pkg::REG_VOLUME:       vol_cfg_q    <= cfg_data_i[twg_pkg::VOL_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.start && restart_i) begin
        phase_acc_q    <= '0;
        sample_index_q <= '0;
      end
      if (cmd_i.finish) begin
        if (last_q) begin
          phase_acc_q    <= '0;
          sample_index_q <= '0;
        end else begin
          phase_acc_q    <= phase_acc_q + phase_step_q;
          sample_index_q <= i_q[INDEX_BITS-1:0] + 1'b1;
        end
      end
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep1) begin
      n_q        <= n_w;
      last_q     <= ((i_ext + 1'b1) >= n_w);
      i_q        <= (i_ext >= n_w) ? (n_w - 1'b1) : i_ext;
      fade_q     <= fade_c[twg_pkg::ENV_W-1:0];
      rom_addr_q <= quad[0] ? (EW'(SINE_TABLE_ENTRIES) - tab_idx) : tab_idx;
    end
    if (cmd_i.prep2) begin
      sine_q <= sine_rom[rom_addr_q];
      if (fade_q == '0) begin
        env_num_q <= twg_pkg::ENV_W'(1);
        env_den_q <= twg_pkg::ENV_W'(1);
      end else if (i_x < f_x) begin
        env_num_q <= i_x[twg_pkg::ENV_W-1:0];
        env_den_q <= fade_q;
      end else if ((i_x + f_x) > n_x) begin
        env_num_q <= n_minus_i[twg_pkg::ENV_W-1:0];
        env_den_q <= fade_q;
      end else begin
        env_num_q <= fade_q;
        env_den_q <= fade_q;
      end
    end
    if (cmd_i.wave) begin
      mag_q <= abs_val[twg_pkg::MAG_W-1:0];
      neg_q <= wave_val[twg_pkg::VAL_W-1];
      vol_q <= (vol_cfg_q > twg_pkg::VOL_MAX) ? twg_pkg::VOL_MAX : vol_cfg_q;
    end
    if (cmd_i.mul1) begin
      a_q <= twg_pkg::PROD_A_W'(mag_q) * twg_pkg::PROD_A_W'(vol_q);
      // env_num * 32767 as shift and subtract
      t_q <= {env_num_q, 15'd0} - twg_pkg::PROD_T_W'(env_num_q);
      d_q <= twg_pkg::DEN_W'(env_den_q) * twg_pkg::DEN_W'(twg_pkg::DIV_SCALE);
    end
    if (cmd_i.mul2) begin
      rem_q <= twg_pkg::REM_W'(a_q) * twg_pkg::REM_W'(t_q);
      dsh_q <= twg_pkg::REM_W'(d_q) << (twg_pkg::QUO_W - 1);
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[twg_pkg::QUO_W-2:0], rem_ge};
      dsh_q <= dsh_q >> 1;
    end
    if (cmd_i.finish) begin
      sample_q   <= neg_q ? -$signed(quo_q) : $signed(quo_q);
      last_out_q <= last_q;
    end
  end

  assign sample_o = sample_q;
  assign last_o   = last_out_q;

endmodule

`default_nettype wire

### rtl/core/tone_waveform_generator.sv
// Top level of the tone waveform generator: sequencer plus datapath.
// Depends on twg_pkg, twg_ctrl and twg_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//  - Configuration channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) writes
//    phase step (0), tone length (1), waveform (2) and volume (3). It is always ready;
//    other indexes are dropped. Write only between samples.
//  - Each transfer on the input channel (in_valid_i/in_ready_o) is one sample tick;
//    restart_i = 1 returns the tone to its first sample before computing it.
//  - Each tick yields one transfer on the output channel (out_valid_o/out_ready_i):
//    a signed 16-bit PCM sample and last_o on the final sample of the tone, after
//    which phase and index restart from zero.
//  - Path from input transfer to out_valid_o: five setup steps (length and fade,
//    table read, waveform, two multiply stages), then the restoring divider
//    producing one of 16 quotient bits per cycle, then the output load, which
//    waits while the output register is full and not being emptied.
//  - One sample at a time: no new tick is taken before the last one is loaded.
//    The input is taken again as soon as the result sits in the output register,
//    even while the receiver holds out_ready_i low.
//  - With the receiver stalled and the output register still full, a finished
//    sample waits in the datapath; no sample is dropped or repeated.
//  - Reset: registers return to their default tone (440 Hz step at 44.1 kHz,
//    22050 samples, sine, 70 percent), phase and index are zero, output empty.

module tone_waveform_generator #(
  parameter int SINE_TABLE_ENTRIES = 1024,
  parameter int FADE_LIMIT         = 882,
  parameter int INDEX_BITS         = 20
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // sample tick input
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              restart_i,
  // PCM output
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [twg_pkg::SAMPLE_W-1:0]    sample_o,
  output logic                                   last_o,
  // configuration writes
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [twg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [twg_pkg::CFG_DAT_W-1:0]     cfg_data_i
);

  twg_pkg::cmd_t cmd;

  // Registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  // Sequencer: one sample at a time, handshakes and output-full tracking
  twg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Phase accumulator, sine table, envelope, products and divider
  twg_datapath #(
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
    .FADE_LIMIT         (FADE_LIMIT),
    .INDEX_BITS         (INDEX_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .restart_i   (restart_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_o    (sample_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

### tb/sv/tone_waveform_generator_checker.sv
// Scoreboard for the tone waveform generator: watches the config, tick and PCM channels,
// predicts each sample and compares it field by field. Depends on twg_pkg.
`timescale 1ns / 1ps

module tone_waveform_generator_checker
  import twg_pkg::*;
#(
  parameter int LUT_SIZE = 1024,
  parameter int FADE_CAP = 882,
  parameter int INDEX_W  = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic                        restart_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic signed [SAMPLE_W-1:0]  sample_i,
  input  logic                        last_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DAT_W-1:0]        cfg_data_i,
  output int                          pending_o,
  output int                          errors_o
);

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } pcm_t;

  // Shadow configuration and tone state
  logic [PHASE_W-1:0] step_q;
  logic [TONE_W-1:0]  len_q;
  wave_e              wave_q;
  logic [VOL_W-1:0]   vol_q;
  logic [31:0]        phase_q;
  logic [INDEX_W-1:0] pos_q;

  int   quarter_lut [LUT_SIZE+1];
  pcm_t pcm_expected_q [$];
  int   err_count = 0;
  int   pending   = 0;

  assign errors_o  = err_count;
  assign pending_o = pending;

  // Quarter-wave point k: Taylor series of sin in Q30, rounded to Q1.15
  function automatic int sine_point(int k);
    longint unsigned x, x2, term;
    longint          sum, q;
    x    = (longint'(k) * PI_HALF_Q30) / LUT_SIZE;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    q = (sum + 64'sd16384) / 64'sd32768;
    if (q > 32767) q = 32767;
    return int'(q);
  endfunction

  initial begin
    for (int k = 0; k <= LUT_SIZE; k++) quarter_lut[k] = sine_point(k);
  end

  // Q1.15 waveform level at phase ph
  function automatic int wave_level(logic [31:0] ph, wave_e sel);
    longint unsigned frac, idx;
    int              u;
    logic [1:0]      quad;
    quad = ph[31:30];
    case (sel)
      WAVE_SINE: begin
        frac = ph[29:0];
        idx  = (frac * LUT_SIZE) >> 30;
        if (quad[0]) idx = LUT_SIZE - idx;
        return quad[1] ? -quarter_lut[idx] : quarter_lut[idx];
      end
      WAVE_SQUARE: return ph[31] ? -32768 : 32768;
      WAVE_TRIANGLE: begin
        u = ph[31:15];
        if (quad == 2'd0) return u;
        if (quad == 2'd3) return u - 131072;
        return 65536 - u;
      end
      default: return int'(ph[31:16]) - 32768;
    endcase
  endfunction

  // One tick: envelope-scaled sample, then advance or wrap the tone
  function automatic pcm_t synth_sample(logic restart);
    longint unsigned n, i, fade, env_num, env_den, vol, mag, num, quo;
    int              lvl, res;
    logic            at_end;
    pcm_t            pcm;
    if (restart) begin
      pos_q   = '0;
      phase_q = '0;
    end
    n = len_q;
    if (n == 0) n = 1;
    if (n > (64'd1 << INDEX_W)) n = 64'd1 << INDEX_W;
    i      = pos_q;
    at_end = (i + 1 >= n);
    if (i >= n) i = n - 1;
    fade = n / 4;
    if (fade > FADE_CAP) fade = FADE_CAP;
    if (fade == 0) begin
      env_num = 1;
      env_den = 1;
    end else if (i < fade) begin
      env_num = i;
      env_den = fade;
    end else if (i + fade > n) begin
      env_num = n - i;
      env_den = fade;
    end else begin
      env_num = fade;
      env_den = fade;
    end
    vol = (vol_q > VOL_MAX) ? VOL_MAX : vol_q;
    lvl = wave_level(phase_q, wave_q);
    mag = (lvl < 0) ? -lvl : lvl;
    num = mag * vol * env_num * 64'd32767;
    quo = num / (64'd3276800 * env_den);
    res = (lvl < 0) ? -int'(quo) : int'(quo);
    pcm.sample = res[SAMPLE_W-1:0];
    pcm.last   = at_end;
    if (at_end) begin
      pos_q   = '0;
      phase_q = '0;
    end else begin
      pos_q   = INDEX_W'(i + 1);
      phase_q = phase_q + step_q;
    end
    return pcm;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pcm_t want;
    if (!rst_ni) begin
      step_q  = PHASE_STEP_RST;
      len_q   = TONE_RST;
      wave_q  = wave_e'(WAVE_RST);
      vol_q   = VOL_RST;
      phase_q = '0;
      pos_q   = '0;
      pcm_expected_q.delete();
      pending = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_PHASE_STEP:   step_q = cfg_data_i[PHASE_W-1:0];
          REG_TONE_SAMPLES: len_q  = cfg_data_i[TONE_W-1:0];
          REG_WAVEFORM:     wave_q = wave_e'(cfg_data_i[WAVE_W-1:0]);
          REG_VOLUME:       vol_q  = cfg_data_i[VOL_W-1:0];
          default: ;  // unmapped index: dropped
        endcase
      end
      if (in_valid_i && in_ready_i) pcm_expected_q.push_back(synth_sample(restart_i));
      if (out_valid_i && out_ready_i) begin
        if (pcm_expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected sample %0d last %0b", sample_i, last_i));
        end else begin
          want = pcm_expected_q.pop_front();
          if (sample_i !== want.sample)
            report_mismatch($sformatf("sample got %0d want %0d", sample_i, want.sample));
          if (last_i !== want.last)
            report_mismatch($sformatf("last got %0b want %0b", last_i, want.last));
        end
      end
      pending = pcm_expected_q.size();
    end
  end

endmodule

### tb/sv/tone_waveform_generator_tb.sv
// Top of the tone waveform generator testbench: clock, reset, stimulus and verdict.
// Depends on twg_pkg, tone_waveform_generator and tone_waveform_generator_checker.
`timescale 1ns / 1ps

module tone_waveform_generator_tb;
  import twg_pkg::*;

  localparam int LUT_SIZE     = 1024;
  localparam int FADE_CAP     = 882;
  localparam int INDEX_W      = 20;
  localparam int REG_COUNT    = 4;      // first unmapped register index
  localparam int RANDOM_TICKS = 1650;
  localparam int SETTLE       = 40;     // longer than one sample's computation

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       tick_valid = 1'b0;
  logic                       tick_ready;
  logic                       restart    = 1'b0;
  logic                       pcm_valid;
  logic                       pcm_ready  = 1'b0;
  logic signed [SAMPLE_W-1:0] pcm_sample;
  logic                       pcm_last;
  logic                       cfg_valid  = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index  = '0;
  logic [CFG_DAT_W-1:0]       cfg_data   = '0;

  int pending;
  int errors;
  bit steady = 1'b0;   // set: no idle gaps on either side
  int ticks_sent = 0;

  tone_waveform_generator #(
    .SINE_TABLE_ENTRIES(LUT_SIZE),
    .FADE_LIMIT        (FADE_CAP),
    .INDEX_BITS        (INDEX_W)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (tick_valid),
    .in_ready_o (tick_ready),
    .restart_i  (restart),
    .out_valid_o(pcm_valid),
    .out_ready_i(pcm_ready),
    .sample_o   (pcm_sample),
    .last_o     (pcm_last),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  tone_waveform_generator_checker #(
    .LUT_SIZE(LUT_SIZE),
    .FADE_CAP(FADE_CAP),
    .INDEX_W (INDEX_W)
  ) scoreboard (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (tick_valid),
    .in_ready_i (tick_ready),
    .restart_i  (restart),
    .out_valid_i(pcm_valid),
    .out_ready_i(pcm_ready),
    .sample_i   (pcm_sample),
    .last_i     (pcm_last),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(31, 120);
  endfunction

  // Receiver side: alternating stall and accept windows, driven on the falling edge
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        pcm_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pcm_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  end

  // All tasks below start and end on a falling edge.
  // cfg_valid stays high across back-to-back writes; end_writes() drops it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
  endtask

  // Unused upper data bits carry noise; the block must mask them
  task automatic configure(logic [31:0] step, logic [TONE_W-1:0] len, wave_e wave,
                           logic [VOL_W-1:0] vol);
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_TONE_SAMPLES, {12'($urandom), len});
    write_reg(REG_WAVEFORM, {30'($urandom), wave});
    write_reg(REG_VOLUME, {25'($urandom), vol});
    end_writes();
  endtask

  // One tick transfer; tick_valid stays high when no gap follows
  task automatic send_tick(logic rs);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_valid <= 1'b1;
    restart    <= rs;
    do @(posedge clk); while (!tick_ready);
    @(negedge clk);
    ticks_sent++;
  endtask

  // Block is idle once every predicted sample has come out
  task automatic drain();
    tick_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [TONE_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return '0;
    if (r < 35) return TONE_W'($urandom_range(1, 8));
    if (r < 65) return TONE_W'($urandom_range(9, 120));
    if (r < 85) return TONE_W'($urandom_range(121, 4000));
    if (r < 95) return TONE_W'($urandom_range(4001, 1048574));
    return '1;
  endfunction

  function automatic logic [31:0] pick_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 40) return $urandom_range(1, 65536);
    if (r < 70) return $urandom_range(1947792, 1947792060);  // 20 Hz .. 20 kHz
    return $urandom;
  endfunction

  function automatic logic [VOL_W-1:0] pick_vol();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return VOL_MAX;
    if (r < 35) return VOL_W'($urandom_range(101, 127));  // clamps to full scale
    return VOL_W'($urandom_range(0, 127));
  endfunction

  // Random reconfiguration: any subset of registers, sometimes a stray index
  task automatic shuffle_regs();
    if ($urandom_range(0, 9) < 7) write_reg(REG_PHASE_STEP, pick_step());
    if ($urandom_range(0, 9) < 7) write_reg(REG_TONE_SAMPLES, {12'($urandom), pick_len()});
    if ($urandom_range(0, 9) < 7) write_reg(REG_WAVEFORM, $urandom);
    if ($urandom_range(0, 9) < 7) write_reg(REG_VOLUME, {25'($urandom), pick_vol()});
    if ($urandom_range(0, 9) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, 2**CFG_IDX_W - 1)), $urandom);
    end_writes();
  endtask

  initial begin
    int count;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset tone: default registers
    send_tick(1'b0);
    send_tick(1'b1);
    drain();

    // Zero length taken as one sample, every tick is last; volume over 100 clamps
    configure(32'hFFFF_FFFF, '0, WAVE_SQUARE, 7'd127);
    send_tick(1'b0);
    send_tick(1'b0);
    drain();

    // Triangle at each quarter boundary, fade of one sample
    configure(32'h4000_0000, 20'd4, WAVE_TRIANGLE, VOL_MAX);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    drain();

    // Sawtooth, length below four: no fade
    configure(32'h2000_0000, 20'd3, WAVE_SAW, 7'd55);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    drain();

    // Sine over all quadrants, hitting the mirrored table end
    configure(32'h2000_0000, 20'd8, WAVE_SINE, VOL_MAX);
    send_tick(1'b1);
    repeat (7) send_tick(1'b0);
    drain();

    // Length cut below the current index mid-tone; stray index write ignored
    write_reg(REG_TONE_SAMPLES, 20'd20);
    end_writes();
    repeat (4) send_tick(1'b0);
    drain();
    write_reg(CFG_IDX_W'(REG_COUNT + 6), '1);
    write_reg(REG_TONE_SAMPLES, 20'd2);
    end_writes();
    send_tick(1'b0);
    send_tick(1'b0);
    drain();

    // Random phases: mostly running tones, occasional restarts
    ticks_sent = 0;
    while (ticks_sent < RANDOM_TICKS) begin
      steady = ($urandom_range(0, 4) == 0);
      shuffle_regs();
      count = $urandom_range(5, 60);
      repeat (count) send_tick($urandom_range(0, 99) < 3);
      drain();
    end
    steady = 1'b0;

    repeat (SETTLE) @(negedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
